>>> rtl/pid_variable_integral_feedforward_core_macros.svh
// Assertion macros for the PID core checker.
// Depends on nothing; included by the checker file.
`ifndef PID_VARIABLE_INTEGRAL_FEEDFORWARD_CORE_MACROS_SVH
`define PID_VARIABLE_INTEGRAL_FEEDFORWARD_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PVIF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvif assertion failed");

// next-cycle implication, disabled in reset
`define PVIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvif assertion failed");

// next-cycle implication that also holds through reset
`define PVIF_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pvif assertion failed");

`endif

>>> rtl/pvif_pkg.sv
// Shared types, register indexes and helpers for the PID core.
// No dependencies.
package pvif_pkg;

    localparam int DataW   = 32;
    localparam int GainW   = 31;
    localparam int CfgIdxW = 4;

    localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN       = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN_STEP = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN_RATE = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CFG_FF_GAIN         = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] CFG_INTEG_LIMIT     = CfgIdxW'(4);
    localparam logic [CfgIdxW-1:0] CFG_OUT_LIMIT       = CfgIdxW'(5);
    localparam logic [CfgIdxW-1:0] CFG_DEAD_BAND       = CfgIdxW'(6);
    localparam logic [CfgIdxW-1:0] CFG_DERIV_ON_MEAS   = CfgIdxW'(7);

    localparam logic MODE_STEP  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic signed [63:0] S32Max = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32Min = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic                    mode;
        logic signed [DataW-1:0] setpoint;
        logic signed [DataW-1:0] measured;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0] drive;
        logic                    clamped;
    } t_result;

    typedef struct packed {
        logic [GainW-1:0] prop_gain;
        logic [GainW-1:0] integ_gain_step;
        logic [GainW-1:0] deriv_gain_rate;
        logic [GainW-1:0] ff_gain;
        logic [GainW-1:0] integ_limit;
        logic [GainW-1:0] out_limit;
        logic [GainW-1:0] dead_band;
        logic             deriv_on_measure;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic                    clear;
        logic signed [DataW-1:0] sp;
        logic signed [DataW-1:0] meas;
        logic signed [DataW-1:0] err;
        logic [DataW-1:0]        aerr;
    } t_job;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] x);
        logic signed [DataW-1:0] y;
        if (x > S32Max) begin
            y = S32Max[DataW-1:0];
        end else if (x < S32Min) begin
            y = S32Min[DataW-1:0];
        end else begin
            y = x[DataW-1:0];
        end
        return y;
    endfunction

endpackage

>>> rtl/pid_variable_integral_feedforward_core.sv
// PID controller core: dead zone, variable-speed separated integral,
// selectable derivative source and reference feedforward.
// Depends on pvif_pkg, pvif_front, pvif_queue, pvif_back.
//
// Input channel i_valid/o_stall carries t_in_item (mode, setpoint, measured);
// output channel o_valid/i_stall carries t_result (drive, clamped). An item
// moves when valid is high and stall is low. Every input item gives one
// result item. Registers are written through i_cfg_valid/o_cfg_ready with
// i_cfg_index and i_cfg_data; the user must write them only while the core
// is idle, which the core itself does not enforce. o_cfg_ready is always 1.
// A step item runs the back end through four products on the single shared
// 33x33 multiplier; a clear item goes straight to the output register.
// When the error falls on the speed ramp the reciprocal ratio step adds three
// more products. The back end takes the next item only after the last one.
// A two-entry queue and the input register keep accepting while the back end
// works; when the receiver stalls, the result holds in the output register,
// the back end waits, the queue fills and then o_stall rises.
// Reset clears registers, integral and history to zero and empties the core.
module pid_variable_integral_feedforward_core
    import pvif_pkg::*;
#(
    parameter int unsigned SEP_THRESHOLD = 0,
    parameter int unsigned SPEED_RAMP    = 0,
    parameter int unsigned SPEED_FULL    = 0,
    parameter int          FRAC_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_in_item           i_item,
    output logic               o_stall,
    output logic               o_valid,
    output t_result            o_result,
    input  logic               i_stall,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [DataW-1:0]   i_cfg_data
);

    t_cfg r_cfg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job front_job;
    t_job head_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:       r_cfg.prop_gain        <= i_cfg_data[GainW-1:0];
                CFG_INTEG_GAIN_STEP: r_cfg.integ_gain_step  <= i_cfg_data[GainW-1:0];
                CFG_DERIV_GAIN_RATE: r_cfg.deriv_gain_rate  <= i_cfg_data[GainW-1:0];
                CFG_FF_GAIN:         r_cfg.ff_gain          <= i_cfg_data[GainW-1:0];
                CFG_INTEG_LIMIT:     r_cfg.integ_limit      <= i_cfg_data[GainW-1:0];
                CFG_OUT_LIMIT:       r_cfg.out_limit        <= i_cfg_data[GainW-1:0];
                CFG_DEAD_BAND:       r_cfg.dead_band        <= i_cfg_data[GainW-1:0];
                CFG_DERIV_ON_MEAS:   r_cfg.deriv_on_measure <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pvif_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .i_dead_band (r_cfg.dead_band),
        .o_push      (q_push),
        .o_job       (front_job),
        .i_full      (q_full)
    );

    pvif_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    pvif_back #(
        .SEP_THRESHOLD (SEP_THRESHOLD),
        .SPEED_RAMP    (SPEED_RAMP),
        .SPEED_FULL    (SPEED_FULL),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (q_empty),
        .i_job    (head_job),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

endmodule

>>> rtl/pvif_front.sv
// Front end: input register, error forming and dead-band classification.
// Depends on pvif_pkg.
module pvif_front
    import pvif_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in_item         i_item,
    output logic             o_stall,
    input  logic [GainW-1:0] i_dead_band,
    output logic             o_push,
    output t_job             o_job,
    input  logic             i_full
);

    logic                    r_valid;
    t_in_item                r_item;
    logic signed [DataW:0]   diff;
    logic signed [DataW-1:0] err_sat;
    logic [DataW-1:0]        aerr;
    logic                    in_band;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        diff    = {r_item.setpoint[DataW-1], r_item.setpoint}
                - {r_item.measured[DataW-1], r_item.measured};
        err_sat = sat32(64'(diff));
        aerr    = err_sat[DataW-1] ? (~err_sat + DataW'(1)) : err_sat;
        in_band = aerr < {1'b0, i_dead_band};

        o_job.clear = (r_item.mode == MODE_CLEAR);
        o_job.meas  = r_item.measured;
        o_job.sp    = in_band ? r_item.measured : r_item.setpoint;
        o_job.err   = in_band ? '0 : err_sat;
        o_job.aerr  = in_band ? '0 : aerr;
    end

endmodule

>>> rtl/pvif_queue.sv
// Two-entry item queue between front and back.
// Depends on pvif_pkg.
module pvif_queue
    import pvif_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wp;
    logic [PtrW-1:0] r_rp;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PtrW'(Depth - 1)) ? '0 : r_wp + PtrW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PtrW'(Depth - 1)) ? '0 : r_rp + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> rtl/pvif_back.sv
// Back end: sequencer around one shared multiplier, reciprocal ratio step,
// integral and history state, output clamp and output register.
// Depends on pvif_pkg.
module pvif_back
    import pvif_pkg::*;
#(
    parameter int unsigned SEP_THRESHOLD = 0,
    parameter int unsigned SPEED_RAMP    = 0,
    parameter int unsigned SPEED_FULL    = 0,
    parameter int          FRAC_BITS     = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_empty,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_stall
);

    localparam int QW = FRAC_BITS;

    localparam logic [DataW:0] Ramp    = (DataW+1)'(SPEED_RAMP);
    localparam logic [DataW:0] Full    = (DataW+1)'(SPEED_FULL);
    localparam logic [DataW:0] Sep     = (DataW+1)'(SEP_THRESHOLD);
    localparam logic [DataW:0] RampEnd = Ramp + Full;
    localparam logic           SpeedOn = (SPEED_RAMP != 0) || (SPEED_FULL != 0);
    localparam logic           SepOn   = (SEP_THRESHOLD != 0);

    // reciprocal of the ramp width, scaled to land in [2^30, 2^31]
    localparam int unsigned       RampDiv  = (SPEED_RAMP == 0) ? 1 : SPEED_RAMP;
    localparam int                RampLog  = $clog2(RampDiv + 1) - 1;
    localparam int                RcpPow   = RampLog + DataW - 1;
    localparam int                RcpShift = RcpPow - FRAC_BITS;
    localparam logic [63:0]       RcpNum   = 64'd1 << RcpPow;
    localparam logic [DataW-1:0]  Recip    = DataW'(RcpNum / 64'(RampDiv));

    typedef enum logic [12:0] {
        S_IDLE = 13'b0_0000_0000_0001,
        S_MI   = 13'b0_0000_0000_0010,
        S_INC  = 13'b0_0000_0000_0100,
        S_DIV  = 13'b0_0000_0000_1000,
        S_QM   = 13'b0_0000_0001_0000,
        S_QC   = 13'b0_0000_0010_0000,
        S_SC   = 13'b0_0000_0100_0000,
        S_SCS  = 13'b0_0000_1000_0000,
        S_INT  = 13'b0_0001_0000_0000,
        S_MD   = 13'b0_0010_0000_0000,
        S_MF   = 13'b0_0100_0000_0000,
        S_FIN  = 13'b0_1000_0000_0000,
        S_LIM  = 13'b1_0000_0000_0000
    } t_state;

    t_state                  r_state;
    t_job                    r_job;
    logic signed [63:0]      r_prod;
    logic signed [DataW-1:0] r_inc;
    logic [DataW-1:0]        r_rem;
    logic [QW-1:0]           r_quot;
    logic signed [63:0]      r_sum;
    logic signed [DataW-1:0] r_integ;
    logic signed [DataW-1:0] r_last_err;
    logic signed [DataW-1:0] r_last_sp;
    logic signed [DataW-1:0] r_last_meas;
    logic                    r_out_valid;
    t_result                 r_out;

    logic [DataW-1:0]        mul_a;
    logic signed [DataW:0]   mul_b;
    logic signed [2*DataW+1:0] mul_full;
    logic signed [63:0]      prod_sh;
    logic signed [DataW-1:0] inc0;
    logic [DataW:0]          aerr_x;
    logic                    in_full;
    logic                    in_ramp;
    logic [QW-1:0]           q_est;
    logic [63:0]             div_rem;
    logic                    div_fix;
    logic signed [DataW-1:0] acc;
    logic                    sep_ok;
    logic signed [DataW-1:0] i_out;
    logic signed [63:0]      ilim;
    logic signed [DataW-1:0] integ_clamped;
    logic signed [DataW:0]   ddiff;
    logic signed [DataW:0]   spdiff;
    logic signed [63:0]      olim;
    logic signed [63:0]      drv64;
    logic signed [DataW-1:0] drv;
    logic                    out_load;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign out_load = (r_state == S_LIM) && (!r_out_valid || !i_stall);

    always_comb begin
        ddiff = i_cfg.deriv_on_measure
              ? ({r_job.meas[DataW-1], r_job.meas} - {r_last_meas[DataW-1], r_last_meas})
              : ({r_job.err[DataW-1], r_job.err} - {r_last_err[DataW-1], r_last_err});
        spdiff = {r_job.sp[DataW-1], r_job.sp} - {r_last_sp[DataW-1], r_last_sp};

        case (r_state)
            S_MI: begin
                mul_a = {1'b0, i_cfg.integ_gain_step};
                mul_b = {r_job.err[DataW-1], r_job.err};
            end
            S_DIV: begin
                mul_a = Recip;
                mul_b = {1'b0, r_rem};
            end
            S_QM: begin
                mul_a = DataW'(q_est);
                mul_b = $signed(Ramp);
            end
            S_SC: begin
                mul_a = DataW'(r_quot);
                mul_b = {r_inc[DataW-1], r_inc};
            end
            S_INT: begin
                mul_a = {1'b0, i_cfg.prop_gain};
                mul_b = {r_job.err[DataW-1], r_job.err};
            end
            S_MD: begin
                mul_a = {1'b0, i_cfg.deriv_gain_rate};
                mul_b = ddiff;
            end
            S_MF: begin
                mul_a = {1'b0, i_cfg.ff_gain};
                mul_b = spdiff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = $signed({1'b0, mul_a}) * mul_b;
    end

    always_comb begin
        prod_sh = r_prod >>> FRAC_BITS;
        inc0    = sat32(prod_sh);
        aerr_x  = {1'b0, r_job.aerr};
        in_full = aerr_x <= Full;
        in_ramp = aerr_x < RampEnd;

        // estimate is the quotient or one below it
        q_est   = QW'(r_prod >> RcpShift);
        div_rem = ({32'b0, r_rem} << FRAC_BITS) - r_prod;
        div_fix = div_rem >= {31'b0, Ramp};

        acc    = sat32(64'(r_integ) + 64'(r_inc));
        sep_ok = !SepOn || (aerr_x < Sep);
        i_out  = sep_ok ? acc : '0;
        ilim   = $signed({33'b0, i_cfg.integ_limit});
        integ_clamped = i_out;
        if (i_cfg.integ_limit != '0 && i_cfg.integ_gain_step != '0) begin
            if (64'(i_out) > ilim) begin
                integ_clamped = ilim[DataW-1:0];
            end else if (64'(i_out) < -ilim) begin
                integ_clamped = -ilim[DataW-1:0];
            end
        end

        olim  = $signed({33'b0, i_cfg.out_limit});
        drv64 = r_sum;
        if (i_cfg.out_limit != '0) begin
            if (r_sum > olim) begin
                drv64 = olim;
            end else if (r_sum < -olim) begin
                drv64 = -olim;
            end
        end
        drv = sat32(drv64);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_last_err  <= '0;
            r_last_sp   <= '0;
            r_last_meas <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_state <= i_job.clear ? S_LIM : S_MI;
                    end
                end
                S_MI: begin
                    r_state <= S_INC;
                end
                S_INC: begin
                    if (SpeedOn && !in_full && in_ramp) begin
                        r_inc   <= inc0;
                        r_rem   <= DataW'(RampEnd - aerr_x);
                        r_state <= S_DIV;
                    end else begin
                        r_inc   <= (SpeedOn && !in_full) ? '0 : inc0;
                        r_state <= S_INT;
                    end
                end
                S_DIV: begin
                    r_state <= S_QM;
                end
                S_QM: begin
                    r_quot  <= q_est;
                    r_state <= S_QC;
                end
                S_QC: begin
                    r_quot  <= div_fix ? (r_quot + QW'(1)) : r_quot;
                    r_state <= S_SC;
                end
                S_SC: begin
                    r_state <= S_SCS;
                end
                S_SCS: begin
                    r_inc   <= prod_sh[DataW-1:0];
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_integ <= integ_clamped;
                    r_sum   <= 64'(i_out);
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_sum   <= r_sum + prod_sh;
                    r_state <= S_MF;
                end
                S_MF: begin
                    r_sum   <= i_cfg.deriv_on_measure ? (r_sum - prod_sh) : (r_sum + prod_sh);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_sum   <= r_sum + prod_sh;
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    if (out_load) begin
                        if (r_job.clear) begin
                            r_out.drive   <= '0;
                            r_out.clamped <= 1'b0;
                            r_integ       <= '0;
                            r_last_err    <= '0;
                            r_last_sp     <= '0;
                            r_last_meas   <= '0;
                        end else begin
                            r_out.drive   <= drv;
                            r_out.clamped <= (64'(drv) != r_sum);
                            r_last_err    <= r_job.err;
                            r_last_sp     <= r_job.sp;
                            r_last_meas   <= r_job.meas;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/pvif_checker.sv
// Port-level checker for the PID core, bound to the top level.
// Depends on pvif_pkg and pid_variable_integral_feedforward_core_macros.svh.
`include "pid_variable_integral_feedforward_core_macros.svh"

module pvif_checker
    import pvif_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input t_in_item           i_item,
    input logic               o_stall,
    input logic               o_valid,
    input t_result            o_result,
    input logic               i_stall,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [CfgIdxW-1:0] i_cfg_index,
    input logic [DataW-1:0]   i_cfg_data
);

    // a stalled result stays put
    `PVIF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result))

    // a limited output is never zero
    `PVIF_ASSERT_IMPL(a_clamp_nonzero, i_clk, i_rst_n, o_valid && o_result.clamped, o_result.drive != 0)

    // reset leaves both channels idle
    `PVIF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind pid_variable_integral_feedforward_core pvif_checker u_pvif_checker (.*);
